>>> rtl/sfir_pkg.sv
`default_nettype none

package sfir_pkg;

    // filter shape
    localparam int TAPS        = 31;
    localparam int SAMPLE_BITS = 10;
    localparam int SUM_SHIFT   = 16;
    localparam int COEF_COUNT  = 31;
    localparam int COEF_BITS   = 8;

    // stream field widths
    localparam int IN_BITS      = 10;
    localparam int OUT_BITS     = 5;
    localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // folded structure: pairs plus an unpaired middle tap for odd lengths
    localparam int NPAIR     = TAPS / 2;
    localparam int UNITS     = NPAIR + (TAPS % 2);
    localparam int GROUPS    = (UNITS + 3) / 4;
    localparam int PSUM_BITS = SAMPLE_BITS + 1;

    // datapath widths
    localparam int TSUM_BITS = COEF_BITS + $clog2(UNITS);
    localparam int ACC_MIN   = TSUM_BITS + PSUM_BITS + 1;
    localparam int ACC_BITS  = (ACC_MIN > SUM_SHIFT + OUT_BITS) ? ACC_MIN
                                                                : SUM_SHIFT + OUT_BITS;
    localparam int STEP_BITS = $clog2(PSUM_BITS + 1);

    localparam logic signed [COEF_BITS-1:0] COEF_TABLE [COEF_COUNT] = '{
        -8'sd1,   8'sd0,   8'sd3,   8'sd6,   8'sd6,   8'sd4,  -8'sd2, -8'sd10,
        -8'sd16, -8'sd17, -8'sd7,   8'sd13,  8'sd43,  8'sd76,  8'sd101, 8'sd111,
         8'sd101, 8'sd76,  8'sd43,  8'sd13, -8'sd7,  -8'sd17, -8'sd16, -8'sd10,
        -8'sd2,   8'sd4,   8'sd6,   8'sd6,   8'sd3,   8'sd0,  -8'sd1
    };

    // control from the sequencer to the tap line
    typedef struct packed {
        logic load;      // shift a new sample into the line
        logic advance;   // run one bit step of the pair adders
        logic low_bits;  // sample bits still coming out (else only carries)
    } t_tap_ctl;

    // control from the sequencer to the accumulator
    typedef struct packed {
        logic clear;
        logic tsum_en;
        logic acc_en;
    } t_acc_ctl;

    // sum of the coefficients of one group of four units picked by sel
    function automatic logic signed [TSUM_BITS-1:0] da_lut(input int grp,
                                                           input logic [3:0] sel);
        logic signed [TSUM_BITS-1:0] tot;
        int unit;
        tot = '0;
        for (int j = 0; j < 4; j++) begin
            unit = grp * 4 + j;
            if (sel[j] && unit < UNITS) begin
                if (unit < COEF_COUNT) begin
                    tot = tot + TSUM_BITS'(COEF_TABLE[unit]);
                end
            end
        end
        return tot;
    endfunction

endpackage

`default_nettype wire

>>> rtl/symmetric_fir_filter.sv
// channel   dir  signals                       contents
// s         in   i_s_tvalid o_s_tready i_s_tdata  sample [9:0]
// m         out  o_m_tvalid i_m_tready o_m_tdata  filtered [4:0] (signed)
//
// each sample is first shifted into the tap line, then the folded pair sums
// come out bit by bit, lsb first, and a last step finishes the sum
// the bit-serial pair adders and the shared accumulator do this work
// reset clears the tap line to zeros and drops any pending result
// a full output register holds the last step until the result is taken
// o_s_tready is high only while no sample is in work
`default_nettype none

module symmetric_fir_filter
    import sfir_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [S_TDATA_BITS-1:0] i_s_tdata,   // [9:0] sample
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic      [M_TDATA_BITS-1:0] o_m_tdata    // [4:0] filtered
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(PSUM_BITS);
    localparam logic [STEP_BITS-1:0] BIT_STEPS = STEP_BITS'(SAMPLE_BITS);

    t_state               r_state;
    logic [STEP_BITS-1:0] r_step;
    logic                 r_out_valid;
    logic [OUT_BITS-1:0]  r_out_data;

    logic                   w_accept;
    logic                   w_run;
    logic                   w_final;
    logic                   w_stall;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [UNITS-1:0]       w_bits;
    logic [OUT_BITS-1:0]    w_result;
    t_tap_ctl               w_tap_ctl;
    t_acc_ctl               w_acc_ctl;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_run      = (r_state == ST_RUN);
    assign w_final    = w_run && (r_step == LAST_STEP);
    assign w_stall    = w_final && r_out_valid && !i_m_tready;
    assign w_sample   = SAMPLE_BITS'(i_s_tdata[IN_BITS-1:0]);

    // step controls
    always_comb begin
        w_tap_ctl.load     = w_accept;
        w_tap_ctl.advance  = w_run && (r_step < LAST_STEP);
        w_tap_ctl.low_bits = (r_step < BIT_STEPS);
        w_acc_ctl.clear    = w_accept;
        w_acc_ctl.tsum_en  = w_run && (r_step < LAST_STEP);
        w_acc_ctl.acc_en   = w_run && (r_step != '0) && !w_stall;
    end

    sfir_tap_line u_tap_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_tap_ctl),
        .i_sample (w_sample),
        .o_bits   (w_bits)
    );

    sfir_da_acc u_da_acc (
        .i_clk    (i_clk),
        .i_ctl    (w_acc_ctl),
        .i_bits   (w_bits),
        .o_result (w_result)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a finished sum refills the register, else a taken result empties it
            if (w_final && !w_stall) begin
                r_out_valid <= 1'b1;
                r_out_data  <= w_result;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_final) begin
                        if (!w_stall) begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_BITS'(r_out_data);

    // a request starts the bit steps from the first plane
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_RUN) && (r_step == '0))
        else $error("bit steps did not start after a request");

    // the step counter never runs past the finishing step
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_run |-> (r_step <= LAST_STEP))
        else $error("step counter out of range");

    // a blocked finish keeps the work in progress
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |=> w_run && (r_step == LAST_STEP))
        else $error("finish step left while output blocked");

    // an unblocked finish presents a result and frees the input
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_final && !w_stall) |=> o_m_tvalid && o_s_tready)
        else $error("finish step did not present a result");

endmodule

`default_nettype wire

>>> rtl/sfir_tap_line.sv
`default_nettype none

module sfir_tap_line
    import sfir_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_tap_ctl               i_ctl,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic      [UNITS-1:0]       o_bits
);

    logic [SAMPLE_BITS-1:0] r_taps [TAPS];
    logic [NPAIR-1:0]       r_carry;
    logic [NPAIR-1:0]       n_carry;

    // bit-serial pair adders, lsb first out of the rotating taps
    always_comb begin
        logic a;
        logic b;
        logic c;
        o_bits  = '0;
        n_carry = '0;
        for (int i = 0; i < NPAIR; i++) begin
            a          = i_ctl.low_bits & r_taps[i][0];
            b          = i_ctl.low_bits & r_taps[TAPS-1-i][0];
            c          = r_carry[i];
            o_bits[i]  = a ^ b ^ c;
            n_carry[i] = (a & b) | (a & c) | (b & c);
        end
        if (UNITS > NPAIR) begin
            o_bits[UNITS-1] = i_ctl.low_bits & r_taps[UNITS-1][0];
        end
    end

    // sample line: shift on load, rotate one bit per step while sample bits remain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_taps[i] <= '0;
            end
            r_carry <= '0;
        end else if (i_ctl.load) begin
            r_taps[0] <= i_sample;
            for (int i = 1; i < TAPS; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
            r_carry <= '0;
        end else if (i_ctl.advance) begin
            r_carry <= n_carry;
            if (i_ctl.low_bits) begin
                for (int i = 0; i < TAPS; i++) begin
                    r_taps[i] <= {r_taps[i][0], r_taps[i][SAMPLE_BITS-1:1]};
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sfir_da_acc.sv
`default_nettype none

module sfir_da_acc
    import sfir_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_acc_ctl            i_ctl,
    input  wire logic [UNITS-1:0]    i_bits,
    output logic      [OUT_BITS-1:0] o_result
);

    logic        [GROUPS*4-1:0]  w_bits;
    logic signed [TSUM_BITS-1:0] w_tsum;
    logic signed [TSUM_BITS-1:0] r_tsum;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  w_text;
    logic signed [ACC_BITS-1:0]  w_sum;
    logic signed [ACC_BITS-1:0]  n_acc;

    assign w_bits = (GROUPS*4)'(i_bits);

    // coefficient sum for one bit plane, four units per table
    always_comb begin
        w_tsum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_tsum = w_tsum + da_lut(g, w_bits[g*4 +: 4]);
        end
    end

    // lsb-first shift-accumulate, weight of the newest plane at the top
    assign w_text = {{(ACC_BITS-TSUM_BITS){r_tsum[TSUM_BITS-1]}}, r_tsum};
    assign w_sum  = r_acc + (w_text <<< PSUM_BITS);
    assign n_acc  = w_sum >>> 1;

    assign o_result = n_acc[SUM_SHIFT +: OUT_BITS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.tsum_en) begin
            r_tsum <= w_tsum;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire
